### hdl/bsfm_pkg.sv
`default_nettype none

package bsfm_pkg;

    localparam int IDX_W  = 6;
    localparam int WORD_W = 32;

    // Operation codes carried in the operation field of a request.
    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Masks of the qualification tests.
    localparam logic [WORD_W-1:0] OUTSIDE_MASK   = 32'hffff_fff5;
    localparam logic [WORD_W-1:0] MODE_MASK      = 32'h0000_078c;
    localparam logic [WORD_W-1:0] MODE_BIT3      = 32'h0000_0008;
    localparam logic [WORD_W-1:0] LOW_FIELD_MASK = 32'hffff_f8ff;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } scan_state_t;

    // Query start from the top level into the scan engine.
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
    } scan_start_t;

    // Status from the scan engine back to the top level.
    typedef struct packed {
        logic              idle;
        logic              done;
        logic [IDX_W-1:0]  index;
        logic [WORD_W-1:0] word;
    } scan_status_t;

endpackage

`default_nettype wire

### hdl/bsfm_table.sv
`default_nettype none

// Flag word table: one write port and one read port, registered read data.
// Per-entry valid bits make entries that were never written read as zero.
module bsfm_table #(
    parameter int ENTRIES = 64,
    parameter int AW      = 6
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [AW-1:0]              wr_addr,
    input  wire logic [bsfm_pkg::WORD_W-1:0] wr_data,
    input  wire logic                       rd_en,
    input  wire logic [AW-1:0]              rd_addr,
    output logic      [bsfm_pkg::WORD_W-1:0] rd_data
);

    logic [bsfm_pkg::WORD_W-1:0] mem [ENTRIES];
    logic [ENTRIES-1:0]          valid_reg;
    logic [bsfm_pkg::WORD_W-1:0] data_reg;
    logic                        rd_valid_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? data_reg : '0;

endmodule

`default_nettype wire

### hdl/bsfm_scan.sv
`default_nettype none

// Scan engine: checks the cache, otherwise walks the table one entry per
// cycle, keeps the best entry so far and updates the cache at the end.
module bsfm_scan #(
    parameter int ENTRIES = 64,
    parameter int AW      = 6
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire bsfm_pkg::scan_start_t       start,
    input  wire logic                        take,
    output logic                             rd_en,
    output logic      [AW-1:0]               rd_addr,
    input  wire logic [bsfm_pkg::WORD_W-1:0] rd_data,
    output bsfm_pkg::scan_status_t           status
);

    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    bsfm_pkg::scan_state_t state_reg, state_next;

    logic [bsfm_pkg::WORD_W-1:0] q_reg, q_next;
    logic [AW-1:0]               addr_reg, addr_next;
    logic                        issued_all_reg, issued_all_next;
    logic [AW-1:0]               eval_idx_reg, eval_idx_next;
    logic                        data_vld_reg, data_vld_next;
    logic [bsfm_pkg::WORD_W-1:0] best_score_reg, best_score_next;
    logic [AW-1:0]               best_idx_reg, best_idx_next;
    logic [bsfm_pkg::WORD_W-1:0] best_word_reg, best_word_next;
    logic [bsfm_pkg::WORD_W-1:0] cached_word_reg, cached_word_next;
    logic [bsfm_pkg::IDX_W-1:0]  cached_idx_reg, cached_idx_next;

    logic                        hit;
    logic [bsfm_pkg::WORD_W-1:0] diff;
    logic                        qualifies;
    logic [bsfm_pkg::WORD_W-1:0] score;
    logic                        better;
    logic                        finish;

    // Entry evaluation on the word that the table returns this cycle.
    always_comb begin
        hit  = (start.word == cached_word_reg);
        diff = (rd_data ^ q_reg) & bsfm_pkg::MODE_MASK;
        qualifies = ((rd_data & ~q_reg & bsfm_pkg::OUTSIDE_MASK) == '0) &&
                    ((diff == '0) ||
                     ((diff == bsfm_pkg::MODE_BIT3) && (q_reg[3] == 1'b1)) ||
                     ((rd_data & bsfm_pkg::LOW_FIELD_MASK) == '0));
        score  = (rd_data & q_reg) - (rd_data & ~q_reg);
        better = data_vld_reg && qualifies && (score > best_score_reg);
        finish = data_vld_reg &&
                 ((better && (rd_data == q_reg)) || (eval_idx_reg == LAST));
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bsfm_pkg::ST_IDLE: begin
                if (start.valid) begin
                    state_next = hit ? bsfm_pkg::ST_DONE : bsfm_pkg::ST_SCAN;
                end
            end
            bsfm_pkg::ST_SCAN: begin
                if (finish) begin
                    state_next = bsfm_pkg::ST_DONE;
                end
            end
            bsfm_pkg::ST_DONE: begin
                if (take) begin
                    state_next = bsfm_pkg::ST_IDLE;
                end
            end
            default: state_next = bsfm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        rd_en        = 1'b0;
        status.idle  = 1'b0;
        status.done  = 1'b0;
        status.index = cached_idx_reg;
        status.word  = cached_word_reg;
        unique case (state_reg)
            bsfm_pkg::ST_IDLE: status.idle = 1'b1;
            bsfm_pkg::ST_SCAN: rd_en = !issued_all_reg && !finish;
            bsfm_pkg::ST_DONE: status.done = 1'b1;
            default: ;
        endcase
    end

    assign rd_addr = addr_reg;

    always_comb begin
        q_next           = q_reg;
        addr_next        = addr_reg;
        issued_all_next  = issued_all_reg;
        eval_idx_next    = eval_idx_reg;
        data_vld_next    = rd_en;
        best_score_next  = best_score_reg;
        best_idx_next    = best_idx_reg;
        best_word_next   = best_word_reg;
        cached_word_next = cached_word_reg;
        cached_idx_next  = cached_idx_reg;

        if ((state_reg == bsfm_pkg::ST_IDLE) && start.valid) begin
            q_next          = start.word;
            addr_next       = '0;
            issued_all_next = 1'b0;
            best_score_next = '0;
            best_idx_next   = '0;
        end

        if (rd_en) begin
            eval_idx_next   = addr_reg;
            issued_all_next = (addr_reg == LAST);
            addr_next       = addr_reg + AW'(1);
        end

        if (data_vld_reg) begin
            // Entry zero is the default answer, so its word is kept as well.
            if (better || (eval_idx_reg == '0)) begin
                best_word_next = rd_data;
            end
            if (better) begin
                best_score_next = score;
                best_idx_next   = eval_idx_reg;
            end
        end

        if (finish) begin
            cached_word_next = best_word_next;
            cached_idx_next  = bsfm_pkg::IDX_W'(best_idx_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg       <= bsfm_pkg::ST_IDLE;
            issued_all_reg  <= 1'b1;
            data_vld_reg    <= 1'b0;
            cached_word_reg <= '0;
            cached_idx_reg  <= '0;
        end
        else begin
            state_reg       <= state_next;
            issued_all_reg  <= issued_all_next;
            data_vld_reg    <= data_vld_next;
            cached_word_reg <= cached_word_next;
            cached_idx_reg  <= cached_idx_next;
        end
    end

    always_ff @(posedge clk) begin
        q_reg          <= q_next;
        addr_reg       <= addr_next;
        eval_idx_reg   <= eval_idx_next;
        best_score_reg <= best_score_next;
        best_idx_reg   <= best_idx_next;
        best_word_reg  <= best_word_next;
    end

endmodule

`default_nettype wire

### hdl/best_subset_flag_match_unit.sv
`default_nettype none

// Channel   Handshake                   Payload
// request   query_valid / query_ready   operation, entry_index, data_word
// result    result_valid / result_ready match_index, matched_word
//
// A write request is stored at its accepting edge; the next may follow at once.
// A query equal to the cached word goes straight to the done state and answers
// from the cache. A miss scans the table one entry per cycle and answers at the
// end of the scan, sooner when an exact match ends the scan early.
// Reset clears the cache and the per-entry valid bits at once. A stalled result
// holds the output register; a finished query that finds it full waits here.
module best_subset_flag_match_unit #(
    parameter int ENTRIES = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        query_valid,
    output logic                             query_ready,
    input  wire logic                        operation,
    input  wire logic [bsfm_pkg::IDX_W-1:0]  entry_index,
    input  wire logic [bsfm_pkg::WORD_W-1:0] data_word,
    output logic                             result_valid,
    input  wire logic                        result_ready,
    output logic      [bsfm_pkg::IDX_W-1:0]  match_index,
    output logic      [bsfm_pkg::WORD_W-1:0] matched_word
);

    // Table address width; a single-entry table still gets one address bit.
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    bsfm_pkg::scan_start_t  start;
    bsfm_pkg::scan_status_t status;

    logic                        accept;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [bsfm_pkg::WORD_W-1:0] rd_data;
    logic                        load;

    logic                        result_valid_reg, result_valid_next;
    logic [bsfm_pkg::IDX_W-1:0]  match_index_reg;
    logic [bsfm_pkg::WORD_W-1:0] matched_word_reg;

    // Requests are taken only while the scan engine is idle.
    assign query_ready = status.idle;
    assign accept      = query_valid && query_ready;

    // Writes beyond the table are dropped.
    assign wr_en   = accept && (operation == bsfm_pkg::OP_WRITE) &&
                     (32'(entry_index) < ENTRIES);
    assign wr_addr = AW'(entry_index);

    assign start.valid = accept && (operation == bsfm_pkg::OP_QUERY);
    assign start.word  = data_word;

    // The output register loads when it is empty or being emptied.
    assign load              = status.done && (!result_valid_reg || result_ready);
    assign result_valid_next = load || (result_valid_reg && !result_ready);

    bsfm_table #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (data_word),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bsfm_scan #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .take    (load),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .status  (status)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_valid_reg <= 1'b0;
        end
        else begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            match_index_reg  <= status.index;
            matched_word_reg <= status.word;
        end
    end

    assign result_valid = result_valid_reg;
    assign match_index  = match_index_reg;
    assign matched_word = matched_word_reg;

endmodule

`default_nettype wire

### hdl/bsfm_checker.sv
`default_nettype none

module bsfm_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        query_valid,
    input wire logic                        query_ready,
    input wire logic                        operation,
    input wire logic                        result_valid,
    input wire logic                        result_ready,
    input wire logic [bsfm_pkg::IDX_W-1:0]  match_index,
    input wire logic [bsfm_pkg::WORD_W-1:0] matched_word
);

    // A stalled result keeps its value.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(match_index) && $stable(matched_word))
        else $error("stalled result changed");

    // A query keeps the block busy for at least the following cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        query_valid && query_ready && (operation == bsfm_pkg::OP_QUERY) |=>
            !query_ready)
        else $error("ready right after a query");

    // A write leaves the block ready for the next request.
    a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
        query_valid && query_ready && (operation == bsfm_pkg::OP_WRITE) |=>
            query_ready)
        else $error("write left the block busy");

    // A write never produces a result.
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        query_valid && query_ready && (operation == bsfm_pkg::OP_WRITE) &&
            !result_valid |=> !result_valid)
        else $error("result after a write");

endmodule

bind best_subset_flag_match_unit bsfm_checker u_bsfm_checker (.*);

`default_nettype wire
